FILE: rtl/csvtok_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csvtok_pkg
// Shared widths, reset values and the result record of the CSV tokenizer.
// ----------------------------------------------------------------------------
package csvtok_pkg;

  localparam int CHAR_W             = 8;
  localparam int CFG_W              = 13;
  localparam int LEN_W              = 12;
  localparam int OUT_DATA_W         = 24;
  localparam int OUT_USER_W         = 2;
  localparam int FIELD_SIZE_MAX_DEF = 4096;
  localparam int MAX_FIELD_SIZE_RST = 256;

  typedef struct packed {
    logic [LEN_W-1:0]  field_length;
    logic              record_done;
    logic              field_done;
    logic              char_kept;
    logic [CHAR_W-1:0] char_out;
  } csvtok_result_t;

endpackage
`default_nettype wire

FILE: rtl/csvtok_fsm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csvtok_fsm
// Character classifier, parser state, kept-character count and field limit.
// ----------------------------------------------------------------------------
module csvtok_fsm #(
  parameter int FIELD_SIZE_MAX = csvtok_pkg::FIELD_SIZE_MAX_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           step,
  input  wire [csvtok_pkg::CHAR_W-1:0]  char_in,
  input  wire                           cfg_wr_en,
  input  wire [csvtok_pkg::CFG_W-1:0]   cfg_wr_data,
  output csvtok_pkg::csvtok_result_t    res
);
  import csvtok_pkg::*;

  localparam int CNT_W   = $clog2(FIELD_SIZE_MAX);
  localparam int LIM_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int LIM_MAX = FIELD_SIZE_MAX - 1;
  localparam int LIM_RST = (MAX_FIELD_SIZE_RST - 1 > LIM_MAX) ? LIM_MAX
                                                              : MAX_FIELD_SIZE_RST - 1;

  localparam logic [2:0] ST_START  = 3'd0;
  localparam logic [2:0] ST_PLAIN  = 3'd1;
  localparam logic [2:0] ST_QUOTED = 3'd2;
  localparam logic [2:0] ST_ESCAPE = 3'd3;
  localparam logic [2:0] ST_OPENED = 3'd4;

  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;

  logic [2:0]       state_r, state_nxt, parse_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [CNT_W-1:0] limit_r, limit_nxt;
  logic [CFG_W-1:0] cfg_dec;
  logic [LIM_W-1:0] cfg_wide;
  logic             is_comma, is_quote, is_eol;
  logic             end_field, end_record, keep;

  assign is_comma = (char_in == CH_COMMA);
  assign is_quote = (char_in == CH_QUOTE);
  assign is_eol   = (char_in == CH_CR) || (char_in == CH_LF);

  // Field ends and record ends leave through end_field/end_record, parse_nxt is unused then
  always_comb begin
    end_field  = 1'b0;
    end_record = 1'b0;
    parse_nxt  = ST_START;
    case (state_r)
      ST_QUOTED, ST_OPENED: begin
        parse_nxt = is_quote ? ST_ESCAPE : ST_QUOTED;
      end
      ST_PLAIN: begin
        end_field  = is_comma || is_eol;
        end_record = is_eol;
        parse_nxt  = ST_PLAIN;
      end
      ST_ESCAPE: begin
        end_field  = is_comma || is_eol;
        end_record = is_eol;
        parse_nxt  = is_quote ? ST_QUOTED : ST_PLAIN;
      end
      default: begin
        end_field  = is_comma || is_eol;
        end_record = is_eol;
        parse_nxt  = is_quote ? ST_OPENED : ST_PLAIN;
      end
    endcase
  end

  assign keep    = !end_field && ((parse_nxt == ST_PLAIN) || (parse_nxt == ST_QUOTED)) &&
                   (cnt_r < limit_r);
  assign cnt_inc = cnt_r + CNT_W'(keep);

  always_comb begin
    res.char_out     = char_in;
    res.char_kept    = keep;
    res.field_done   = end_field;
    res.record_done  = end_record;
    res.field_length = LEN_W'(cnt_inc);
    cnt_nxt          = end_field ? '0 : cnt_inc;
    state_nxt        = end_field ? ST_START : parse_nxt;
  end

  // Size register stored as the keep limit: size minus one, saturated
  assign cfg_dec   = (cfg_wr_data == '0) ? '0 : cfg_wr_data - 1'b1;
  assign cfg_wide  = LIM_W'(cfg_dec);
  assign limit_nxt = (cfg_wide > LIM_W'(LIM_MAX)) ? CNT_W'(LIM_MAX) : CNT_W'(cfg_wide);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
      cnt_r   <= '0;
      limit_r <= CNT_W'(LIM_RST);
    end else begin
      if (step) begin
        state_r <= state_nxt;
        cnt_r   <= cnt_nxt;
      end
      if (cfg_wr_en) begin
        limit_r <= limit_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_record_is_field: assert property (@(posedge clk) disable iff (!rst_n)
    res.record_done |-> res.field_done)
    else $error("record end without field end");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.field_done) |=> (cnt_r == '0) && (state_r == ST_START))
    else $error("parser not back at start after field end");

  a_keep_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.char_kept) |=> (cnt_r == CNT_W'($past(cnt_r) + 1'b1)))
    else $error("kept character not counted");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(cnt_r) && $stable(state_r))
    else $error("parser state moved without a request");
`endif

endmodule
`default_nettype wire

FILE: rtl/csvtok_oreg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csvtok_oreg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module csvtok_oreg (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                load,
  input  csvtok_pkg::csvtok_result_t         res,
  output logic                               in_ready,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [csvtok_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [csvtok_pkg::OUT_USER_W-1:0]  out_tuser,
  output logic                               out_tlast
);
  import csvtok_pkg::*;

  logic           valid_r, valid_nxt;
  csvtok_result_t res_r;

  assign in_ready  = !valid_r || out_tready;
  assign valid_nxt = load || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tlast  = res_r.record_done;
  assign out_tuser  = {res_r.field_done, res_r.char_kept};
  assign out_tdata  = {4'b0000, res_r.field_length, res_r.char_out};

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_tready) |-> !load)
    else $error("result overwritten while stalled");
`endif

endmodule
`default_nettype wire

FILE: rtl/csv_field_tokenizer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csv_field_tokenizer_top
// CSV field tokenizer: one character in, one classified result out.
// ----------------------------------------------------------------------------
// Takes one character byte per request and returns one registered result per
// character. The parser state and the kept count update in the same cycle as
// the character is accepted, so a character is taken every clock while the
// result register is empty or being drained; throughput is one character per
// cycle while the receiver keeps up. A comma ends a field, CR or LF ends a
// field and the record (out_tlast); CR LF therefore also gives an empty
// record. Characters beyond max_field_size - 1 of a field are dropped
// (char_kept low) but still parsed. Write cfg_wr_data only while idle.
module csv_field_tokenizer_top #(
  parameter int FIELD_SIZE_MAX = csvtok_pkg::FIELD_SIZE_MAX_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire [csvtok_pkg::CHAR_W-1:0]       in_tdata,    // [7:0] char_in
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // [7:0] char_out, [19:8] field_length, [23:20] zero
  output logic [csvtok_pkg::OUT_DATA_W-1:0]  out_tdata,
  // [0] char_kept, [1] field_done
  output logic [csvtok_pkg::OUT_USER_W-1:0]  out_tuser,
  output logic                               out_tlast,   // record_done
  input  wire                                cfg_wr_en,
  input  wire [csvtok_pkg::CFG_W-1:0]        cfg_wr_data  // max_field_size
);
  import csvtok_pkg::*;

  logic           step;
  csvtok_result_t res;

  assign step = in_tvalid && in_tready;

  csvtok_fsm #(
    .FIELD_SIZE_MAX (FIELD_SIZE_MAX)
  ) u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .char_in     (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res         (res)
  );

  csvtok_oreg u_oreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .res        (res),
    .in_ready   (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CSV field tokenizer.
// ----------------------------------------------------------------------------
// Feeds characters through the input stream and predicts every result with
// its own parser model: state, kept count and the field size register. A
// short directed sequence walks every character class through every parser
// state but a plain character in the opened-quote state. Then random records,
// quoted and plain, with some noise, across several field sizes: zero, one,
// small, the maximum and the saturating top of the range. One long field runs
// under the saturated size register. Both stream sides idle at random, apart
// from two clean stretches, and the receiver stalls once to back up the input.
module tb;
  import csvtok_pkg::*;

  localparam int          CLK_HALF   = 4;
  localparam int          CYCLE_CAP  = 200000;
  localparam int          KEEP_CEIL  = FIELD_SIZE_MAX_DEF - 1;
  localparam logic [7:0]  CH_COMMA   = 8'h2C;
  localparam logic [7:0]  CH_QUOTE   = 8'h22;
  localparam logic [7:0]  CH_CR      = 8'h0D;
  localparam logic [7:0]  CH_LF      = 8'h0A;

  typedef enum logic [2:0] {
    PS_START, PS_PLAIN, PS_QUOTED, PS_ESCAPE, PS_OPENED, PS_FIELD, PS_RECORD
  } parse_state_e;

  typedef enum logic [1:0] {CC_COMMA, CC_QUOTE, CC_EOL, CC_OTHER} char_class_e;

  class field_scoreboard;
    csvtok_result_t    expected_q[$];
    parse_state_e      state;
    logic [LEN_W-1:0]  kept_count;
    logic [CFG_W-1:0]  field_size;
    int unsigned       fails;

    function new();
      state      = PS_START;
      kept_count = '0;
      field_size = CFG_W'(MAX_FIELD_SIZE_RST);
      fails      = 0;
    endfunction

    function void set_size(logic [CFG_W-1:0] v);
      field_size = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_char(logic [CHAR_W-1:0] c);
      char_class_e    cls;
      parse_state_e   nxt;
      int unsigned    limit;
      csvtok_result_t r;
      if (c == CH_COMMA) cls = CC_COMMA;
      else if (c == CH_QUOTE) cls = CC_QUOTE;
      else if (c == CH_CR || c == CH_LF) cls = CC_EOL;
      else cls = CC_OTHER;
      case (state)
        PS_QUOTED, PS_OPENED: begin
          nxt = (cls == CC_QUOTE) ? PS_ESCAPE : PS_QUOTED;
        end
        PS_ESCAPE: begin
          case (cls)
            CC_COMMA: nxt = PS_FIELD;
            CC_QUOTE: nxt = PS_QUOTED;
            CC_EOL:   nxt = PS_RECORD;
            default:  nxt = PS_PLAIN;
          endcase
        end
        PS_PLAIN: begin
          case (cls)
            CC_COMMA: nxt = PS_FIELD;
            CC_EOL:   nxt = PS_RECORD;
            default:  nxt = PS_PLAIN;
          endcase
        end
        default: begin
          case (cls)
            CC_COMMA: nxt = PS_FIELD;
            CC_QUOTE: nxt = PS_OPENED;
            CC_EOL:   nxt = PS_RECORD;
            default:  nxt = PS_PLAIN;
          endcase
        end
      endcase
      limit = (field_size == 0) ? 0 : field_size - 1;
      if (limit > KEEP_CEIL) limit = KEEP_CEIL;
      r = '0;
      r.char_out = c;
      if (nxt == PS_FIELD || nxt == PS_RECORD) begin
        r.field_done   = 1'b1;
        r.record_done  = (nxt == PS_RECORD);
        r.field_length = kept_count;
        kept_count     = '0;
        state          = PS_START;
      end else begin
        if ((nxt == PS_PLAIN || nxt == PS_QUOTED) && kept_count < limit) begin
          r.char_kept = 1'b1;
          kept_count  = kept_count + 1'b1;
        end
        r.field_length = kept_count;
        state          = nxt;
      end
      expected_q.push_back(r);
    endfunction

    function void compare(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        fails++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user,
                               logic last);
      csvtok_result_t e;
      if (expected_q.size() == 0) begin
        $error("result: none expected, got data 0x%06h user %0b last %0b", data, user, last);
        fails++;
        return;
      end
      e = expected_q.pop_front();
      compare("char_out", e.char_out, data[7:0]);
      compare("char_kept", e.char_kept, user[0]);
      compare("field_done", e.field_done, user[1]);
      compare("field_length", e.field_length, data[19:8]);
      compare("pad", 0, data[23:20]);
      compare("record_done", e.record_done, last);
    endfunction
  endclass

  logic                    clk         = 1'b0;
  logic                    rst_n       = 1'b0;
  logic                    in_tvalid   = 1'b0;
  logic                    in_tready;
  logic [CHAR_W-1:0]       in_tdata    = '0;
  logic                    out_tvalid;
  logic                    out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic [OUT_USER_W-1:0]   out_tuser;
  logic                    out_tlast;
  logic                    cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0]        cfg_wr_data = '0;

  field_scoreboard sb = new();
  bit              gaps_on      = 1'b1;
  bit              hold_request = 1'b0;
  int unsigned     cycles       = 0;
  int unsigned     sent_chars   = 0;

  csv_field_tokenizer_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin
    while (cycles < CYCLE_CAP) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold on request.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(gaps_on && $urandom_range(99) < 28);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
  end

  task automatic push_char(input logic [7:0] c);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 28) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_char(c);
    sent_chars++;
  endtask

  // Drop the request line and let every pending result drain.
  task automatic settle_block();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_field_size(input logic [CFG_W-1:0] v);
    settle_block();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.set_size(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == CH_COMMA || b == CH_QUOTE || b == CH_CR || b == CH_LF);
    return b;
  endfunction

  task automatic send_record();
    int nfields;
    int len;
    bit quoted;
    logic [7:0] b;
    nfields = $urandom_range(1, 4);
    for (int f = 0; f < nfields; f++) begin
      quoted = ($urandom_range(99) < 35);
      len = ($urandom_range(99) < 90) ? $urandom_range(0, 6) : $urandom_range(7, 24);
      if (quoted) push_char(CH_QUOTE);
      for (int k = 0; k < len; k++) begin
        if (quoted) begin
          b = 8'($urandom_range(255));
          push_char(b);
          if (b == CH_QUOTE) push_char(CH_QUOTE);
        end else begin
          push_char(plain_byte());
        end
      end
      if (quoted) push_char(CH_QUOTE);
      if (f < nfields - 1) push_char(CH_COMMA);
    end
    case ($urandom_range(2))
      0: push_char(CH_LF);
      1: push_char(CH_CR);
      default: begin
        push_char(CH_CR);
        push_char(CH_LF);
      end
    endcase
  endtask

  // Noise leans on the special characters to break sequences mid-way.
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(4))
        0: push_char(CH_COMMA);
        1: push_char(CH_QUOTE);
        2: push_char($urandom_range(1) ? CH_CR : CH_LF);
        default: push_char(8'($urandom_range(255)));
      endcase
    end
  endtask

  initial begin
    logic [7:0]       directed[$];
    logic [CFG_W-1:0] sizes[$];
    int               phase_start;
    directed = '{"a", CH_COMMA, CH_QUOTE, CH_COMMA, CH_COMMA, CH_QUOTE, CH_QUOTE,
                 CH_LF, "q", CH_QUOTE, "x", CH_QUOTE, CH_CR, CH_LF,
                 CH_QUOTE, CH_QUOTE, CH_COMMA, CH_QUOTE, CH_CR, CH_QUOTE, CH_LF,
                 CH_COMMA, 8'h00, 8'hFF, CH_COMMA};
    sizes = '{13'd4, 13'd1, 13'd0, 13'd2, 13'd8191, 13'd3, 13'd7, 13'd4096,
              CFG_W'($urandom_range(1, 40))};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) push_char(directed[i]);

    // Zero and one keep nothing; two keeps a single character.
    for (int s = 0; s < 3; s++) begin
      write_field_size(CFG_W'(s));
      foreach (directed[i]) push_char(directed[i]);
    end

    // Long field under the saturated limit: every character is kept.
    write_field_size(13'd8191);
    gaps_on = 1'b0;
    for (int k = 0; k < 300; k++) push_char("a");
    push_char(CH_COMMA);
    gaps_on = 1'b1;

    sent_chars = 0;
    foreach (sizes[p]) begin
      write_field_size(sizes[p]);
      gaps_on = (p != 0);
      if (p == 1) hold_request = 1'b1;
      phase_start = sent_chars;
      while (sent_chars - phase_start < 130) begin
        if ($urandom_range(99) < 80) send_record();
        else send_noise();
      end
    end
    gaps_on = 1'b1;

    settle_block();
    repeat (5) @(posedge clk);
    if (sb.fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
